### rtl/qtsb_pkg.sv
// ----------------------------------------------------------------------------
// qtsb_pkg
// Shared constants, codes and control structures of the quantisation table
// set builder.
// ----------------------------------------------------------------------------
package qtsb_pkg;

   localparam int TABLE_COUNT  = 5;
   localparam int HALF_ENTRIES = 128;
   localparam int MAX_CONTEXTS = 32768;

   localparam int STORE_DEPTH = TABLE_COUNT * HALF_ENTRIES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TAB_W       = $clog2(TABLE_COUNT + 1);
   localparam int POS_W       = $clog2(HALF_ENTRIES + 1);
   localparam int FACTOR_W    = POS_W + 1;

   localparam int CMD_W     = 2;
   localparam int RUN_W     = 8;
   localparam int LEN_W     = RUN_W + 1;
   localparam int RD_TAB_W  = 3;
   localparam int ENTRY_W   = 8;
   localparam int STATUS_W  = 3;
   localparam int CNT_W     = 16;
   localparam int RVAL_W    = 32;
   localparam int VALUE_W   = 31;
   localparam int SCALE_W   = 40;
   localparam int PROD_W    = SCALE_W + POS_W;

   localparam logic [PROD_W-1:0]  VALUE_LIMIT = PROD_W'(64'h7FFF_FFFF);
   localparam logic [SCALE_W-1:0] CNT_MAX     = SCALE_W'(64'hFFFF);

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_BAD   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_COMPLETE     = 3'd1,
      ST_RUN_PAST_END = 3'd2,
      ST_OVERFLOW     = 3'd3,
      ST_CONTEXTS     = 3'd4,
      ST_BAD_CMD      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_FILL,
      S_SCALE,
      S_FINISH,
      S_READ
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       begin_set;
      logic       read_issue;
      logic       calc_prod;
      logic       fill_write;
      logic       scale_update;
      logic       finish;
      logic       load_read;
      logic       latch_error;
      logic       respond;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    err;
      logic    tables_done;
      logic    run_long;
      logic    overflow;
      logic    fill_last;
      logic    half_full;
      logic    table_last;
      logic    read_bad;
      logic    ctx_bad;
   } dp_status_type;

endpackage

### rtl/quant_table_set_builder.sv
// ----------------------------------------------------------------------------
// quant_table_set_builder
// Builds a set of quantisation tables from run symbols and serves reads.
// A begin or rejected command answers from the decode state, a value overflow
// from the check state and a read from the read state; a run symbol passes the
// check, then the fill loop writes one entry per cycle, then a scale update when a
// table closes and a finish step on the last table. One transaction at a time:
// busy drops in the strobe cycle, so the next one may be accepted there; results
// cannot be stalled. Reset clears the set state (scale one, error clear); the table store is not cleared.
// ----------------------------------------------------------------------------
module quant_table_set_builder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [qtsb_pkg::CMD_W-1:0]           req_cmd,
   input  logic [qtsb_pkg::RUN_W-1:0]           req_run_minus_one,
   input  logic [qtsb_pkg::RD_TAB_W-1:0]        req_read_table,
   input  logic [qtsb_pkg::ENTRY_W-1:0]         req_read_entry,
   output logic                                 rsp_valid,
   output logic [qtsb_pkg::STATUS_W-1:0]        rsp_status,
   output logic [qtsb_pkg::CNT_W-1:0]           rsp_contexts,
   output logic signed [qtsb_pkg::RVAL_W-1:0]   rsp_read_value,
   output logic                                 rsp_set_done
);

   qtsb_pkg::ctrl_cmd_type  dp_cmd;
   qtsb_pkg::dp_status_type dp_status;

   qtsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   qtsb_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .req_cmd           (req_cmd),
      .req_run_minus_one (req_run_minus_one),
      .req_read_table    (req_read_table),
      .req_read_entry    (req_read_entry),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_contexts      (rsp_contexts),
      .rsp_read_value    (rsp_read_value),
      .rsp_set_done      (rsp_set_done)
   );

endmodule

### rtl/qtsb_ram.sv
// ----------------------------------------------------------------------------
// qtsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qtsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/qtsb_ctrl.sv
// ----------------------------------------------------------------------------
// qtsb_ctrl
// Sequencer: decodes each transaction and steps the datapath through the
// checks, the entry fill loop, the scale update and the completion check.
// ----------------------------------------------------------------------------
module qtsb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  qtsb_pkg::dp_status_type dp_status,
   output qtsb_pkg::ctrl_cmd_type  dp_cmd
);

   qtsb_pkg::state_type state_ff;
   qtsb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qtsb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qtsb_pkg::S_IDLE: begin
            if (start) begin
               state_in = qtsb_pkg::S_DECODE;
            end
         end
         qtsb_pkg::S_DECODE: begin
            unique case (dp_status.cmd)
               qtsb_pkg::CMD_READ: begin
                  state_in = dp_status.read_bad ? qtsb_pkg::S_IDLE : qtsb_pkg::S_READ;
               end
               qtsb_pkg::CMD_RUN: begin
                  if (dp_status.err || dp_status.tables_done || dp_status.run_long) begin
                     state_in = qtsb_pkg::S_IDLE;
                  end else begin
                     state_in = qtsb_pkg::S_CHECK;
                  end
               end
               default: state_in = qtsb_pkg::S_IDLE;
            endcase
         end
         qtsb_pkg::S_CHECK: begin
            state_in = dp_status.overflow ? qtsb_pkg::S_IDLE : qtsb_pkg::S_FILL;
         end
         qtsb_pkg::S_FILL: begin
            if (dp_status.fill_last) begin
               state_in = dp_status.half_full ? qtsb_pkg::S_SCALE : qtsb_pkg::S_IDLE;
            end
         end
         qtsb_pkg::S_SCALE: begin
            state_in = dp_status.table_last ? qtsb_pkg::S_FINISH : qtsb_pkg::S_IDLE;
         end
         qtsb_pkg::S_FINISH: state_in = qtsb_pkg::S_IDLE;
         qtsb_pkg::S_READ:   state_in = qtsb_pkg::S_IDLE;
         default:            state_in = qtsb_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd        = '0;
      dp_cmd.status = qtsb_pkg::ST_OK;
      busy          = (state_ff != qtsb_pkg::S_IDLE);
      unique case (state_ff)
         qtsb_pkg::S_IDLE: begin
            dp_cmd.capture = start;
         end
         qtsb_pkg::S_DECODE: begin
            unique case (dp_status.cmd)
               qtsb_pkg::CMD_BEGIN: begin
                  dp_cmd.begin_set = 1'b1;
                  dp_cmd.respond   = 1'b1;
               end
               qtsb_pkg::CMD_READ: begin
                  if (dp_status.read_bad) begin
                     dp_cmd.respond = 1'b1;
                     dp_cmd.status  = qtsb_pkg::ST_BAD_CMD;
                  end else begin
                     dp_cmd.read_issue = 1'b1;
                  end
               end
               qtsb_pkg::CMD_RUN: begin
                  if (dp_status.err || dp_status.tables_done) begin
                     dp_cmd.respond = 1'b1;
                     dp_cmd.status  = qtsb_pkg::ST_BAD_CMD;
                  end else if (dp_status.run_long) begin
                     dp_cmd.respond     = 1'b1;
                     dp_cmd.latch_error = 1'b1;
                     dp_cmd.status      = qtsb_pkg::ST_RUN_PAST_END;
                  end else begin
                     dp_cmd.calc_prod = 1'b1;
                  end
               end
               default: begin
                  dp_cmd.respond = 1'b1;
                  dp_cmd.status  = qtsb_pkg::ST_BAD_CMD;
               end
            endcase
         end
         qtsb_pkg::S_CHECK: begin
            if (dp_status.overflow) begin
               dp_cmd.respond     = 1'b1;
               dp_cmd.latch_error = 1'b1;
               dp_cmd.status      = qtsb_pkg::ST_OVERFLOW;
            end
         end
         qtsb_pkg::S_FILL: begin
            dp_cmd.fill_write = 1'b1;
            dp_cmd.respond    = dp_status.fill_last && !dp_status.half_full;
         end
         qtsb_pkg::S_SCALE: begin
            dp_cmd.scale_update = 1'b1;
            dp_cmd.respond      = !dp_status.table_last;
         end
         qtsb_pkg::S_FINISH: begin
            dp_cmd.respond = 1'b1;
            if (dp_status.ctx_bad) begin
               dp_cmd.latch_error = 1'b1;
               dp_cmd.status      = qtsb_pkg::ST_CONTEXTS;
            end else begin
               dp_cmd.finish = 1'b1;
               dp_cmd.status = qtsb_pkg::ST_COMPLETE;
            end
         end
         qtsb_pkg::S_READ: begin
            dp_cmd.load_read = 1'b1;
            dp_cmd.respond   = 1'b1;
         end
         default: begin
            dp_cmd = '0;
         end
      endcase
   end

endmodule

### rtl/qtsb_dp.sv
// ----------------------------------------------------------------------------
// qtsb_dp
// Datapath: transaction capture, set state, value multiplier, scale update,
// context count check, table store and response registers.
// ----------------------------------------------------------------------------
module qtsb_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qtsb_pkg::ctrl_cmd_type               dp_cmd,
   output qtsb_pkg::dp_status_type              dp_status,
   input  logic [qtsb_pkg::CMD_W-1:0]           req_cmd,
   input  logic [qtsb_pkg::RUN_W-1:0]           req_run_minus_one,
   input  logic [qtsb_pkg::RD_TAB_W-1:0]        req_read_table,
   input  logic [qtsb_pkg::ENTRY_W-1:0]         req_read_entry,
   output logic                                 rsp_valid,
   output logic [qtsb_pkg::STATUS_W-1:0]        rsp_status,
   output logic [qtsb_pkg::CNT_W-1:0]           rsp_contexts,
   output logic signed [qtsb_pkg::RVAL_W-1:0]   rsp_read_value,
   output logic                                 rsp_set_done
);

   // captured transaction
   qtsb_pkg::cmd_type                  cmd_ff;
   logic [qtsb_pkg::RUN_W-1:0]         run_ff;
   logic [qtsb_pkg::RD_TAB_W-1:0]      rtab_ff;
   logic [qtsb_pkg::ENTRY_W-1:0]       rent_ff;

   // set state
   logic [qtsb_pkg::SCALE_W-1:0]       scale_ff;
   logic [qtsb_pkg::SCALE_W-1:0]       scale_in;
   logic [qtsb_pkg::POS_W-1:0]         fill_ff;
   logic [qtsb_pkg::POS_W-1:0]         level_ff;
   logic [qtsb_pkg::TAB_W-1:0]         table_ff;
   logic [qtsb_pkg::CNT_W-1:0]         contexts_ff;
   logic [qtsb_pkg::CNT_W-1:0]         contexts_in;
   logic                               err_ff;

   logic [qtsb_pkg::PROD_W-1:0]        prod_ff;
   logic [qtsb_pkg::PROD_W-1:0]        prod_in;
   logic [qtsb_pkg::RUN_W-1:0]         run_left_ff;
   logic                               mirror_ff;

   logic                               rsp_valid_ff;
   qtsb_pkg::status_type               rsp_status_ff;
   logic signed [qtsb_pkg::RVAL_W-1:0] rsp_value_ff;
   logic signed [qtsb_pkg::RVAL_W-1:0] rsp_value_in;

   logic [qtsb_pkg::LEN_W-1:0]         run_len;
   logic [qtsb_pkg::LEN_W-1:0]         free_len;
   logic [qtsb_pkg::FACTOR_W-1:0]      factor;
   logic [qtsb_pkg::SCALE_W:0]         scale_inc;
   logic [qtsb_pkg::SCALE_W-1:0]       ctx;
   logic [qtsb_pkg::ENTRY_W:0]         rd_offset;
   logic [qtsb_pkg::ADDR_W-1:0]        wr_addr;
   logic [qtsb_pkg::ADDR_W-1:0]        rd_addr;
   logic [qtsb_pkg::VALUE_W-1:0]       rd_data;
   logic [qtsb_pkg::RVAL_W-1:0]        rd_ext;

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff  <= qtsb_pkg::cmd_type'(req_cmd);
         run_ff  <= req_run_minus_one;
         rtab_ff <= req_read_table;
         rent_ff <= req_read_entry;
      end
      if (dp_cmd.calc_prod) begin
         prod_ff <= prod_in;
      end
      if (dp_cmd.read_issue) begin
         mirror_ff <= (int'(rent_ff) >= qtsb_pkg::HALF_ENTRIES);
      end
      if (dp_cmd.calc_prod) begin
         run_left_ff <= run_ff;
      end else if (dp_cmd.fill_write) begin
         run_left_ff <= run_left_ff - qtsb_pkg::RUN_W'(1);
      end
      if (dp_cmd.respond) begin
         rsp_status_ff <= dp_cmd.status;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || dp_cmd.begin_set) begin
         scale_ff    <= qtsb_pkg::SCALE_W'(1);
         fill_ff     <= '0;
         level_ff    <= '0;
         table_ff    <= '0;
         contexts_ff <= '0;
         err_ff      <= 1'b0;
      end else begin
         if (dp_cmd.fill_write) begin
            fill_ff <= fill_ff + qtsb_pkg::POS_W'(1);
            if (run_left_ff == '0) begin
               level_ff <= level_ff + qtsb_pkg::POS_W'(1);
            end
         end
         if (dp_cmd.scale_update) begin
            scale_ff <= scale_in;
            fill_ff  <= '0;
            level_ff <= '0;
            table_ff <= table_ff + qtsb_pkg::TAB_W'(1);
         end
         if (dp_cmd.finish) begin
            contexts_ff <= contexts_in;
         end
         if (dp_cmd.latch_error) begin
            err_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_cmd.respond;
      end
   end

   // run checks
   assign run_len  = qtsb_pkg::LEN_W'(run_ff) + qtsb_pkg::LEN_W'(1);
   assign free_len = qtsb_pkg::LEN_W'(qtsb_pkg::HALF_ENTRIES) - qtsb_pkg::LEN_W'(fill_ff);
   assign prod_in  = qtsb_pkg::PROD_W'(level_ff) * qtsb_pkg::PROD_W'(scale_ff);

   // scale grows by 2*levels-1 once a table is full; level already counts the last run
   assign factor   = {level_ff, 1'b0} - qtsb_pkg::FACTOR_W'(1);
   assign scale_in = qtsb_pkg::SCALE_W'(scale_ff * qtsb_pkg::SCALE_W'(factor));

   assign scale_inc   = {1'b0, scale_ff} + (qtsb_pkg::SCALE_W + 1)'(1);
   assign ctx         = scale_inc[qtsb_pkg::SCALE_W:1];
   assign contexts_in = (ctx > qtsb_pkg::CNT_MAX) ? '1 : ctx[qtsb_pkg::CNT_W-1:0];

   // upper half mirrors the lower half around the middle entry
   always_comb begin
      if (int'(rent_ff) < qtsb_pkg::HALF_ENTRIES) begin
         rd_offset = {1'b0, rent_ff};
      end else if (int'(rent_ff) == qtsb_pkg::HALF_ENTRIES) begin
         rd_offset = (qtsb_pkg::ENTRY_W + 1)'(qtsb_pkg::HALF_ENTRIES - 1);
      end else begin
         rd_offset = (qtsb_pkg::ENTRY_W + 1)'(2 * qtsb_pkg::HALF_ENTRIES) - {1'b0, rent_ff};
      end
   end

   assign rd_addr = qtsb_pkg::ADDR_W'(rtab_ff) * qtsb_pkg::ADDR_W'(qtsb_pkg::HALF_ENTRIES)
                    + qtsb_pkg::ADDR_W'(rd_offset);
   assign wr_addr = qtsb_pkg::ADDR_W'(table_ff) * qtsb_pkg::ADDR_W'(qtsb_pkg::HALF_ENTRIES)
                    + qtsb_pkg::ADDR_W'(fill_ff);

   qtsb_ram #(
      .WIDTH (qtsb_pkg::VALUE_W),
      .DEPTH (qtsb_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (dp_cmd.fill_write),
      .wr_addr (wr_addr),
      .wr_data (prod_ff[qtsb_pkg::VALUE_W-1:0]),
      .rd_en   (dp_cmd.read_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_ext = {1'b0, rd_data};

   always_comb begin
      rsp_value_in = '0;
      if (dp_cmd.load_read) begin
         rsp_value_in = mirror_ff ? $signed(qtsb_pkg::RVAL_W'(0) - rd_ext) : $signed(rd_ext);
      end
   end

   always_comb begin
      dp_status             = '0;
      dp_status.cmd         = cmd_ff;
      dp_status.err         = err_ff;
      dp_status.tables_done = (int'(table_ff) >= qtsb_pkg::TABLE_COUNT);
      dp_status.run_long    = (run_len > free_len);
      dp_status.overflow    = (scale_ff == '0) || (prod_ff > qtsb_pkg::VALUE_LIMIT);
      dp_status.fill_last   = (run_left_ff == '0);
      dp_status.half_full   = (fill_ff + qtsb_pkg::POS_W'(1)
                               == qtsb_pkg::POS_W'(qtsb_pkg::HALF_ENTRIES));
      dp_status.table_last  = (int'(table_ff) + 1 == qtsb_pkg::TABLE_COUNT);
      dp_status.read_bad    = (int'(rtab_ff) >= qtsb_pkg::TABLE_COUNT)
                              || (int'(rent_ff) >= 2 * qtsb_pkg::HALF_ENTRIES);
      dp_status.ctx_bad     = (ctx == '0)
                              || (ctx > qtsb_pkg::SCALE_W'(qtsb_pkg::MAX_CONTEXTS));
   end

   // set state is stable while the response is shown
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_contexts   = contexts_ff;
   assign rsp_set_done   = (int'(table_ff) >= qtsb_pkg::TABLE_COUNT) && !err_ff;

endmodule

### verif/quant_table_set_builder_tb.sv
// ----------------------------------------------------------------------------
// quant_table_set_builder_tb
// Self-checking bench for the quantisation table set builder. Commands go in
// on the start/busy handshake in random bursts; every response strobe is
// checked against a bit-accurate prediction of the set state and the table
// store. Most of the stimulus builds whole sets with random run layouts, some
// of them deliberately broken, mixed with reads and rejected commands.
// ----------------------------------------------------------------------------
module quant_table_set_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 550;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 150;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      qtsb_pkg::status_type        status;
      logic [qtsb_pkg::CNT_W-1:0]  contexts;
      logic [qtsb_pkg::RVAL_W-1:0] value;
      logic                        done;
   } answer_type;

   typedef enum {
      SET_GOOD,
      SET_TOO_WIDE,
      SET_PAST_END,
      SET_ABANDON,
      SET_DEEP
   } set_plan_type;

   class scoreboard_type;
      logic [qtsb_pkg::VALUE_W-1:0] table_mem [qtsb_pkg::STORE_DEPTH];
      bit                           written   [qtsb_pkg::STORE_DEPTH];
      longint unsigned              scale_now;
      int unsigned                  fill_pos;
      int unsigned                  level_now;
      int unsigned                  cur_tbl;
      logic [qtsb_pkg::CNT_W-1:0]   contexts_now;
      bit                           err_held;
      qtsb_pkg::status_type         last_status;
      answer_type                   expected_answers [$];
      int                           failures;
      int                           checked;
      int                           reads_served;
      int                           status_seen [6];

      function new();
         foreach (written[i]) begin
            written[i]   = 1'b0;
            table_mem[i] = '0;
         end
         foreach (status_seen[i]) status_seen[i] = 0;
         failures     = 0;
         checked      = 0;
         reads_served = 0;
         last_status  = qtsb_pkg::ST_OK;
         clear_set();
      endfunction

      function void clear_set();
         scale_now    = 1;
         fill_pos     = 0;
         level_now    = 0;
         cur_tbl      = 0;
         contexts_now = '0;
         err_held     = 1'b0;
      endfunction

      // upper half mirrors the lower half, entry 128 folds onto 127
      function int unsigned mirror_index(int unsigned tab, int unsigned ent);
         if (ent < qtsb_pkg::HALF_ENTRIES) return tab * qtsb_pkg::HALF_ENTRIES + ent;
         if (ent == qtsb_pkg::HALF_ENTRIES)
            return tab * qtsb_pkg::HALF_ENTRIES + qtsb_pkg::HALF_ENTRIES - 1;
         return tab * qtsb_pkg::HALF_ENTRIES + 2 * qtsb_pkg::HALF_ENTRIES - ent;
      endfunction

      function bit readable(int unsigned tab, int unsigned ent);
         if (tab >= qtsb_pkg::TABLE_COUNT || ent >= 2 * qtsb_pkg::HALF_ENTRIES) return 1'b0;
         return written[mirror_index(tab, ent)];
      endfunction

      function qtsb_pkg::status_type fill_run(int unsigned run_m1);
         int unsigned     len;
         longint unsigned product;
         longint unsigned ctx;
         len = run_m1 + 1;
         if (err_held || cur_tbl >= qtsb_pkg::TABLE_COUNT) return qtsb_pkg::ST_BAD_CMD;
         if (len > qtsb_pkg::HALF_ENTRIES - fill_pos) begin
            err_held = 1'b1;
            return qtsb_pkg::ST_RUN_PAST_END;
         end
         if (scale_now == 0 || level_now > 64'(qtsb_pkg::VALUE_LIMIT) / scale_now) begin
            err_held = 1'b1;
            return qtsb_pkg::ST_OVERFLOW;
         end
         product = level_now * scale_now;
         repeat (len) begin
            table_mem[cur_tbl * qtsb_pkg::HALF_ENTRIES + fill_pos] =
               qtsb_pkg::VALUE_W'(product);
            written[cur_tbl * qtsb_pkg::HALF_ENTRIES + fill_pos] = 1'b1;
            fill_pos++;
         end
         level_now++;
         if (fill_pos < qtsb_pkg::HALF_ENTRIES) return qtsb_pkg::ST_OK;
         // table closed: widen the scale and move on
         scale_now = (scale_now * (2 * level_now - 1)) & 64'hFF_FFFF_FFFF;
         fill_pos  = 0;
         level_now = 0;
         cur_tbl++;
         if (cur_tbl < qtsb_pkg::TABLE_COUNT) return qtsb_pkg::ST_OK;
         ctx = (scale_now + 1) / 2;
         if (ctx == 0 || ctx > qtsb_pkg::MAX_CONTEXTS) begin
            err_held = 1'b1;
            return qtsb_pkg::ST_CONTEXTS;
         end
         contexts_now = (ctx > 64'hFFFF) ? '1 : qtsb_pkg::CNT_W'(ctx);
         return qtsb_pkg::ST_COMPLETE;
      endfunction

      function void note_request(qtsb_pkg::cmd_type cmd,
                                 logic [qtsb_pkg::RUN_W-1:0] run_m1,
                                 logic [qtsb_pkg::RD_TAB_W-1:0] tab,
                                 logic [qtsb_pkg::ENTRY_W-1:0] ent);
         answer_type                   ans;
         logic [qtsb_pkg::VALUE_W-1:0] stored;
         ans.value = '0;
         case (cmd)
            qtsb_pkg::CMD_BEGIN: begin
               clear_set();
               ans.status = qtsb_pkg::ST_OK;
            end
            qtsb_pkg::CMD_RUN: ans.status = fill_run(run_m1);
            qtsb_pkg::CMD_READ: begin
               if (tab >= qtsb_pkg::TABLE_COUNT || ent >= 2 * qtsb_pkg::HALF_ENTRIES) begin
                  ans.status = qtsb_pkg::ST_BAD_CMD;
               end else begin
                  ans.status = qtsb_pkg::ST_OK;
                  stored     = table_mem[mirror_index(tab, ent)];
                  ans.value  = (ent < qtsb_pkg::HALF_ENTRIES)
                               ? qtsb_pkg::RVAL_W'(stored)
                               : qtsb_pkg::RVAL_W'(0) - qtsb_pkg::RVAL_W'(stored);
                  reads_served++;
               end
            end
            default: ans.status = qtsb_pkg::ST_BAD_CMD;
         endcase
         ans.contexts = contexts_now;
         ans.done     = (cur_tbl >= qtsb_pkg::TABLE_COUNT) && !err_held;
         last_status  = ans.status;
         status_seen[int'(ans.status)]++;
         expected_answers.insert(expected_answers.size(), ans);
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= REPORT_MAX) $display("mismatch at result %0d: %s", checked, what);
      endfunction

      function void check_result(logic [qtsb_pkg::STATUS_W-1:0] status,
                                 logic [qtsb_pkg::CNT_W-1:0] contexts,
                                 logic [qtsb_pkg::RVAL_W-1:0] value, logic done);
         answer_type want;
         if (expected_answers.size() == 0) begin
            flag("response strobe with no transaction outstanding");
            return;
         end
         want = expected_answers.pop_front();
         checked++;
         if (status !== want.status)
            flag($sformatf("status expected %0d got %0d", want.status, status));
         if (contexts !== want.contexts)
            flag($sformatf("contexts expected %0d got %0d", want.contexts, contexts));
         if (value !== want.value)
            flag($sformatf("read_value expected %0d got %0d",
                           $signed(want.value), $signed(value)));
         if (done !== want.done)
            flag($sformatf("set_done expected %0b got %0b", want.done, done));
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [qtsb_pkg::CMD_W-1:0]          req_cmd = '0;
   logic [qtsb_pkg::RUN_W-1:0]          req_run_minus_one = '0;
   logic [qtsb_pkg::RD_TAB_W-1:0]       req_read_table = '0;
   logic [qtsb_pkg::ENTRY_W-1:0]        req_read_entry = '0;
   logic                                rsp_valid;
   logic [qtsb_pkg::STATUS_W-1:0]       rsp_status;
   logic [qtsb_pkg::CNT_W-1:0]          rsp_contexts;
   logic signed [qtsb_pkg::RVAL_W-1:0]  rsp_read_value;
   logic                                rsp_set_done;

   scoreboard_type sb;
   int             items_sent  = 0;
   int             burst_left  = 0;
   int unsigned    cycle_count = 0;

   quant_table_set_builder u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_run_minus_one (req_run_minus_one),
      .req_read_table    (req_read_table),
      .req_read_entry    (req_read_entry),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_contexts      (rsp_contexts),
      .rsp_read_value    (rsp_read_value),
      .rsp_set_done      (rsp_set_done)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_result(rsp_status, rsp_contexts, rsp_read_value, rsp_set_done);
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   task automatic issue(qtsb_pkg::cmd_type cmd, logic [qtsb_pkg::RUN_W-1:0] run_m1,
                        logic [qtsb_pkg::RD_TAB_W-1:0] tab,
                        logic [qtsb_pkg::ENTRY_W-1:0] ent);
      int gap;
      if (burst_left == 0) begin
         // now and then a long stretch with no idle cycles at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 12);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      start             <= 1'b1;
      req_cmd           <= cmd;
      req_run_minus_one <= run_m1;
      req_read_table    <= tab;
      req_read_entry    <= ent;
      do @(posedge clock); while (busy);
      sb.note_request(cmd, run_m1, tab, ent);
      items_sent++;
   endtask

   // read an entry already written, or fall back to an out-of-range table
   task automatic send_read();
      int unsigned tab;
      int unsigned ent;
      tab = $urandom_range(0, qtsb_pkg::TABLE_COUNT - 1);
      ent = $urandom_range(0, 2 * qtsb_pkg::HALF_ENTRIES - 1);
      for (int tries = 0; tries < 16 && !sb.readable(tab, ent); tries++) begin
         tab = $urandom_range(0, qtsb_pkg::TABLE_COUNT - 1);
         ent = $urandom_range(0, 2 * qtsb_pkg::HALF_ENTRIES - 1);
      end
      if (sb.readable(tab, ent))
         issue(qtsb_pkg::CMD_READ, rand_byte(), qtsb_pkg::RD_TAB_W'(tab),
               qtsb_pkg::ENTRY_W'(ent));
      else
         issue(qtsb_pkg::CMD_READ, rand_byte(),
               qtsb_pkg::RD_TAB_W'($urandom_range(qtsb_pkg::TABLE_COUNT, 7)),
               qtsb_pkg::ENTRY_W'(ent));
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 1) == 0)
         issue(qtsb_pkg::CMD_BAD, rand_byte(), qtsb_pkg::RD_TAB_W'($urandom), rand_byte());
      else
         issue(qtsb_pkg::CMD_READ, rand_byte(),
               qtsb_pkg::RD_TAB_W'($urandom_range(qtsb_pkg::TABLE_COUNT, 7)), rand_byte());
   endtask

   task automatic play_set(set_plan_type plan);
      int              levels [qtsb_pkg::TABLE_COUNT];
      int              lens   [qtsb_pkg::HALF_ENTRIES];
      longint          product;
      int              lmax;
      int              stop_tbl;
      int              stop_run;
      int              idx;
      product = 1;
      for (int t = 0; t < qtsb_pkg::TABLE_COUNT; t++) begin
         case (plan)
            SET_TOO_WIDE: levels[t] = $urandom_range(9, 14);
            SET_DEEP: levels[t] = (t < qtsb_pkg::TABLE_COUNT - 1) ? $urandom_range(40, 60)
                                                                  : qtsb_pkg::HALF_ENTRIES;
            default: begin
               // keep the final context count within range
               lmax = int'(((2 * qtsb_pkg::MAX_CONTEXTS - 1) / product + 1) / 2);
               if (lmax > qtsb_pkg::HALF_ENTRIES) lmax = qtsb_pkg::HALF_ENTRIES;
               if ($urandom_range(0, 7) != 0 && lmax > 6) lmax = 6;
               levels[t] = $urandom_range(1, lmax);
            end
         endcase
         product = product * (2 * levels[t] - 1);
      end
      stop_tbl = $urandom_range(0, qtsb_pkg::TABLE_COUNT - 1);
      stop_run = $urandom_range(0, levels[stop_tbl] - 1);

      issue(qtsb_pkg::CMD_BEGIN, rand_byte(), qtsb_pkg::RD_TAB_W'($urandom), rand_byte());
      for (int t = 0; t < qtsb_pkg::TABLE_COUNT; t++) begin
         // spread the table's entries over the planned number of levels
         for (int r = 0; r < levels[t]; r++) lens[r] = 1;
         repeat (qtsb_pkg::HALF_ENTRIES - levels[t]) begin
            idx = $urandom_range(0, levels[t] - 1);
            lens[idx]++;
         end
         for (int r = 0; r < levels[t]; r++) begin
            if (t == stop_tbl && r == stop_run && plan == SET_ABANDON) return;
            if (t == stop_tbl && r == stop_run && plan == SET_PAST_END) begin
               issue(qtsb_pkg::CMD_RUN,
                     qtsb_pkg::RUN_W'($urandom_range(qtsb_pkg::HALF_ENTRIES - sb.fill_pos,
                                                     255)),
                     qtsb_pkg::RD_TAB_W'($urandom), rand_byte());
               repeat ($urandom_range(1, 3))
                  issue(qtsb_pkg::CMD_RUN, rand_byte(), qtsb_pkg::RD_TAB_W'($urandom),
                        rand_byte());
               if ($urandom_range(0, 1) == 0) send_read();
               return;
            end
            issue(qtsb_pkg::CMD_RUN, qtsb_pkg::RUN_W'(lens[r] - 1),
                  qtsb_pkg::RD_TAB_W'($urandom), rand_byte());
            if (plan == SET_DEEP && sb.last_status == qtsb_pkg::ST_OVERFLOW) begin
               issue(qtsb_pkg::CMD_RUN, rand_byte(), qtsb_pkg::RD_TAB_W'($urandom),
                     rand_byte());
               return;
            end
            if ($urandom_range(0, 3) == 0) send_read();
            if ($urandom_range(0, 15) == 0) send_noise();
         end
      end
      repeat ($urandom_range(1, 4)) send_read();
      // a run after the set has closed must be refused
      if ($urandom_range(0, 2) == 0)
         issue(qtsb_pkg::CMD_RUN, rand_byte(), qtsb_pkg::RD_TAB_W'($urandom), rand_byte());
   endtask

   initial begin
      int           directed_count;
      int           deep_at;
      bit           deep_done;
      int           pick;
      set_plan_type plan;
      sb        = new();
      deep_done = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rejected commands and errors straight out of reset
      issue(qtsb_pkg::CMD_BAD, 8'hFF, 3'd7, 8'hFF);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd5, 8'h00);
      issue(qtsb_pkg::CMD_READ, 8'hA5, 3'd7, 8'hFF);
      issue(qtsb_pkg::CMD_RUN, 8'hFF, 3'd0, 8'h00);
      issue(qtsb_pkg::CMD_RUN, 8'h00, 3'd2, 8'h5A);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd6, 8'h80);
      // small set: two levels in the first table, one in each of the rest
      issue(qtsb_pkg::CMD_BEGIN, 8'h00, 3'd0, 8'h00);
      issue(qtsb_pkg::CMD_RUN, 8'd0, 3'd1, 8'h01);
      issue(qtsb_pkg::CMD_RUN, 8'd126, 3'd4, 8'h7F);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd0, 8'd0);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd0, 8'd1);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd0, 8'd127);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd0, 8'd128);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd0, 8'd129);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd0, 8'd255);
      repeat (qtsb_pkg::TABLE_COUNT - 1) issue(qtsb_pkg::CMD_RUN, 8'd127, 3'd3, 8'hC3);
      issue(qtsb_pkg::CMD_RUN, 8'd0, 3'd0, 8'h00);
      issue(qtsb_pkg::CMD_BAD, 8'h3C, 3'd4, 8'h66);
      issue(qtsb_pkg::CMD_READ, 8'h00, 3'd4, 8'd200);
      directed_count = items_sent;

      deep_at = $urandom_range(20, 300);
      while (items_sent < directed_count + RANDOM_ITEMS) begin
         if (!deep_done && items_sent >= directed_count + deep_at) begin
            play_set(SET_DEEP);
            deep_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5)      plan = SET_GOOD;
            else if (pick < 7) plan = SET_PAST_END;
            else if (pick < 8) plan = SET_ABANDON;
            else               plan = SET_TOO_WIDE;
            play_set(plan);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses over %0d transactions: %0d sets completed, %0d reads.",
               sb.checked, items_sent, sb.status_seen[int'(qtsb_pkg::ST_COMPLETE)],
               sb.reads_served);
      $display("Errors provoked: %0d past end, %0d value overflow, %0d context range, %0d refused.",
               sb.status_seen[int'(qtsb_pkg::ST_RUN_PAST_END)],
               sb.status_seen[int'(qtsb_pkg::ST_OVERFLOW)],
               sb.status_seen[int'(qtsb_pkg::ST_CONTEXTS)],
               sb.status_seen[int'(qtsb_pkg::ST_BAD_CMD)]);
      if (sb.failures > 0)
         $display("%0d mismatches in total", sb.failures);
      if (sb.failures == 0 && sb.expected_answers.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
